>>> rtl/core/qsra_pkg.sv
// ----------------------------------------------------------------------------
// qsra_pkg
// Shared types, codes, widths and tree helpers for the quadtree square region
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package qsra_pkg;

  // field widths
  localparam int OP_W       = 1;
  localparam int LEVEL_W    = 3;
  localparam int ID_W       = 9;
  localparam int POS_W      = 14;
  localparam int LAYER_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int TSL_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ST_W       = 5;
  localparam int FREE_BIT   = 4;

  // default tree shape
  localparam int DEF_TREE_DEPTH = 4;
  localparam int DEF_NODE_COUNT = 341;

  // node status values
  localparam logic [ST_W-1:0] ST_FREE   = 5'h1F;
  localparam logic [ST_W-1:0] FREE_MASK = 5'h10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER    = 1'b1;

  localparam logic [TSL_W-1:0] TSL_RESET = 4'd12;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] RS_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] RS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] RS_FREED    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    id;
  } qsra_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
  } qsra_res_t;

  // node count of a subtree rooted at the given level: 1 + 4 + 16 + ...
  function automatic logic [15:0] sub_size(input logic [LEVEL_W-1:0] level,
                                           input int depth);
    logic [15:0] s;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      if (k + int'(level) <= depth) s[2*k] = 1'b1;
    end
    return s;
  endfunction

  // slot times subtree size, slot in 0..3
  function automatic logic [15:0] times_slot(input logic [1:0] s, input logic [15:0] c);
    return (s[0] ? c : 16'd0) + (s[1] ? {c[14:0], 1'b0} : 16'd0);
  endfunction

  // side of a child of a node at the given level, wrapped to the position width
  function automatic logic [POS_W-1:0] half_off(input logic [TSL_W-1:0] tsl,
                                                input logic [LEVEL_W-1:0] level);
    logic [4:0]       sh;
    logic [POS_W-1:0] res;
    res = '0;
    sh  = '0;
    if ({1'b0, tsl} >= ({2'b00, level} + 5'd1)) begin
      sh = {1'b0, tsl} - {2'b00, level} - 5'd1;
      if (sh < 5'(POS_W)) res = POS_W'(1) << sh;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qsra_if.sv
// ----------------------------------------------------------------------------
// qsra request / response channels
// Valid-ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsra_req_if;
  logic                          valid;
  logic                          ready;
  logic [qsra_pkg::OP_W-1:0]     op;
  logic [qsra_pkg::LEVEL_W-1:0]  size_level;
  logic [qsra_pkg::ID_W-1:0]     node_id;

  modport source (output valid, op, size_level, node_id, input ready);
  modport sink   (input valid, op, size_level, node_id, output ready);
endinterface

interface qsra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [qsra_pkg::STATUS_W-1:0] status;
  logic [qsra_pkg::ID_W-1:0]     granted_id;
  logic [qsra_pkg::POS_W-1:0]    pos_x;
  logic [qsra_pkg::POS_W-1:0]    pos_y;
  logic [qsra_pkg::LAYER_W-1:0]  layer_out;

  modport source (output valid, status, granted_id, pos_x, pos_y, layer_out, input ready);
  modport sink   (input valid, status, granted_id, pos_x, pos_y, layer_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qsra_engine.sv
// ----------------------------------------------------------------------------
// qsra_engine
// Tree walker: node status memory, ancestor stack and the sequencer that
// runs allocate searches, frees and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module qsra_engine #(
  parameter int TREE_DEPTH = qsra_pkg::DEF_TREE_DEPTH,
  parameter int NODE_COUNT = qsra_pkg::DEF_NODE_COUNT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire qsra_pkg::qsra_cmd_t          cmd,
  input  wire logic [qsra_pkg::TSL_W-1:0]   top_size_log2,
  output logic                              ready,
  output logic                              res_valid,
  output qsra_pkg::qsra_res_t               res,
  input  wire logic                         res_ready
);

  localparam int FULL = int'(qsra_pkg::sub_size(3'd0, TREE_DEPTH));
  localparam int IDW  = (qsra_pkg::ID_W > $clog2(FULL + 1)) ? qsra_pkg::ID_W
                                                             : $clog2(FULL + 1);
  localparam int AW   = $clog2(NODE_COUNT);
  localparam int LW   = $clog2(TREE_DEPTH + 1);
  localparam int SW   = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
  localparam int STW  = qsra_pkg::ST_W;
  localparam int PW   = qsra_pkg::POS_W;
  localparam int LVW  = qsra_pkg::LEVEL_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_RET   = 9'b000010000,
    S_FWALK = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]  clr_addr, clr_addr_next;
  logic [LW-1:0]  sp, sp_next;
  logic [2:0]     k, k_next;
  logic           ret_hit, ret_hit_next;
  logic           all_free, all_free_next;
  logic [STW-1:0] ret_st, ret_st_next;
  logic           op_free, op_free_next;
  logic [LVW-1:0] want, want_next;
  logic [IDW-1:0] req_id, req_id_next;
  logic [IDW-1:0] cur_id, cur_id_next;
  logic [PW-1:0]  cur_x, cur_x_next;
  logic [PW-1:0]  cur_y, cur_y_next;

  // ancestor stack, read and written at the top only
  logic [IDW-1:0] stk_id [TREE_DEPTH];
  logic [STW-1:0] stk_st [TREE_DEPTH];
  logic [1:0]     stk_ci [TREE_DEPTH];
  logic [PW-1:0]  stk_x  [TREE_DEPTH];
  logic [PW-1:0]  stk_y  [TREE_DEPTH];

  logic           stk_we;
  logic [SW-1:0]  stk_wi;
  logic [IDW-1:0] stk_wid;
  logic [STW-1:0] stk_wst;
  logic [1:0]     stk_wci;
  logic [PW-1:0]  stk_wx;
  logic [PW-1:0]  stk_wy;

  // node status memory
  logic [STW-1:0] mem [NODE_COUNT];
  logic           mem_we;
  logic [IDW-1:0] wr_id;
  logic [AW-1:0]  mem_wa;
  logic [STW-1:0] mem_wd;
  logic [IDW-1:0] rd_id;
  logic           rd_inr;
  logic [AW-1:0]  mem_ra;
  logic [STW-1:0] rd_q;
  logic           rd_ok;
  logic [STW-1:0] st_rd;

  // helpers
  logic [SW-1:0]  top_idx;
  logic [IDW-1:0] par_id;
  logic [STW-1:0] par_st;
  logic [1:0]     par_ci;
  logic [PW-1:0]  par_x;
  logic [PW-1:0]  par_y;
  logic [15:0]    csz_child;
  logic [15:0]    csz_walk;
  logic [15:0]    full_walk;
  logic [PW-1:0]  h_par;
  logic [PW-1:0]  h_walk;
  logic [1:0]     ni;
  logic [STW-1:0] v_ret;
  logic [IDW-1:0] d_walk;
  logic [1:0]     pick;
  logic           walk_out;

  assign top_idx   = SW'(sp - LW'(1));
  assign par_id    = stk_id[top_idx];
  assign par_st    = stk_st[top_idx];
  assign par_ci    = stk_ci[top_idx];
  assign par_x     = stk_x[top_idx];
  assign par_y     = stk_y[top_idx];
  assign csz_child = qsra_pkg::sub_size(LVW'(sp), TREE_DEPTH);
  assign csz_walk  = qsra_pkg::sub_size(LVW'(sp) + 3'd1, TREE_DEPTH);
  assign full_walk = qsra_pkg::sub_size(LVW'(sp), TREE_DEPTH);
  assign h_par     = qsra_pkg::half_off(top_size_log2, LVW'(sp) - 3'd1);
  assign h_walk    = qsra_pkg::half_off(top_size_log2, LVW'(sp));
  assign ni        = par_ci + 2'd1;
  assign st_rd     = rd_ok ? rd_q : '0;

  // parent status on return: drop an exhausted child's bit, free bit on a grant
  always_comb begin
    v_ret = par_st & ~((ret_st == '0) ? (STW'(1) << par_ci) : '0);
    if (ret_hit) v_ret = v_ret & ~qsra_pkg::FREE_MASK;
  end

  // free descent: which child subtree holds the id
  assign d_walk   = req_id - cur_id - IDW'(1);
  assign walk_out = (sp == LW'(TREE_DEPTH)) || (req_id < cur_id) ||
                    ({1'b0, req_id} >= ({1'b0, cur_id} + (IDW+1)'(full_walk)));
  always_comb begin
    priority if (d_walk >= IDW'(qsra_pkg::times_slot(2'd3, csz_walk))) pick = 2'd3;
    else if (d_walk >= IDW'(qsra_pkg::times_slot(2'd2, csz_walk)))     pick = 2'd2;
    else if (d_walk >= IDW'(csz_walk))                                 pick = 2'd1;
    else                                                               pick = 2'd0;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    sp_next       = sp;
    k_next        = k;
    ret_hit_next  = ret_hit;
    all_free_next = all_free;
    ret_st_next   = ret_st;
    op_free_next  = op_free;
    want_next     = want;
    req_id_next   = req_id;
    cur_id_next   = cur_id;
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    stk_we        = 1'b0;
    stk_wi        = SW'(sp);
    stk_wid       = cur_id;
    stk_wst       = st_rd;
    stk_wci       = 2'd0;
    stk_wx        = cur_x;
    stk_wy        = cur_y;
    mem_we        = 1'b0;
    wr_id         = cur_id;
    mem_wd        = '0;
    rd_id         = cur_id;

    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        wr_id  = IDW'(clr_addr);
        mem_wd = qsra_pkg::ST_FREE;
        if (clr_addr == AW'(NODE_COUNT - 1)) state_next = S_IDLE;
        else clr_addr_next = clr_addr + AW'(1);
      end

      S_IDLE: begin
        if (start) begin
          op_free_next = (cmd.op == qsra_pkg::OP_FREE);
          want_next    = cmd.level;
          req_id_next  = IDW'(cmd.id);
          sp_next      = '0;
          cur_id_next  = '0;
          cur_x_next   = '0;
          cur_y_next   = '0;
          ret_hit_next = 1'b0;
          state_next   = (cmd.op == qsra_pkg::OP_FREE) ? S_FWALK : S_READ;
        end
      end

      S_READ: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (st_rd == '0) begin
          ret_hit_next = 1'b0;
          ret_st_next  = '0;
          state_next   = (sp == '0) ? S_DONE : S_RET;
        end else if (LVW'(sp) == want) begin
          if (st_rd[qsra_pkg::FREE_BIT]) begin
            mem_we       = 1'b1;
            wr_id        = cur_id;
            mem_wd       = '0;
            ret_hit_next = 1'b1;
            ret_st_next  = '0;
          end else begin
            ret_hit_next = 1'b0;
            ret_st_next  = st_rd;
          end
          state_next = (sp == '0) ? S_DONE : S_RET;
        end else if (sp == LW'(TREE_DEPTH)) begin
          ret_hit_next = 1'b0;
          ret_st_next  = st_rd;
          state_next   = (sp == '0) ? S_DONE : S_RET;
        end else begin
          // descend into child 0, same corner as the parent
          stk_we      = 1'b1;
          stk_wi      = SW'(sp);
          sp_next     = sp + LW'(1);
          cur_id_next = cur_id + IDW'(1);
          state_next  = S_READ;
        end
      end

      S_RET: begin
        if (ret_hit || par_ci == 2'd3) begin
          mem_we      = 1'b1;
          wr_id       = par_id;
          mem_wd      = v_ret;
          ret_st_next = v_ret;
          sp_next     = sp - LW'(1);
          state_next  = (sp == LW'(1)) ? S_DONE : S_RET;
        end else begin
          // move on to the next sibling
          stk_we      = 1'b1;
          stk_wi      = top_idx;
          stk_wid     = par_id;
          stk_wst     = v_ret;
          stk_wci     = ni;
          stk_wx      = par_x;
          stk_wy      = par_y;
          cur_id_next = par_id + IDW'(1) + IDW'(qsra_pkg::times_slot(ni, csz_child));
          cur_x_next  = par_x + (ni[0] ? h_par : '0);
          cur_y_next  = par_y + (ni[1] ? h_par : '0);
          state_next  = S_READ;
        end
      end

      S_FWALK: begin
        if (cur_id == req_id) begin
          ret_hit_next = (req_id < IDW'(NODE_COUNT));
          if (req_id < IDW'(NODE_COUNT)) begin
            mem_we        = 1'b1;
            wr_id         = req_id;
            mem_wd        = qsra_pkg::ST_FREE;
            k_next        = '0;
            all_free_next = 1'b1;
            state_next    = (sp == '0) ? S_DONE : S_FRD;
          end else begin
            state_next = S_DONE;
          end
        end else if (walk_out) begin
          ret_hit_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          stk_we      = 1'b1;
          stk_wi      = SW'(sp);
          stk_wci     = pick;
          sp_next     = sp + LW'(1);
          cur_id_next = cur_id + IDW'(1) + IDW'(qsra_pkg::times_slot(pick, csz_walk));
          cur_x_next  = cur_x + (pick[0] ? h_walk : '0);
          cur_y_next  = cur_y + (pick[1] ? h_walk : '0);
        end
      end

      S_FRD: begin
        // four children first, then the parent itself
        if (k == 3'd4) rd_id = par_id;
        else rd_id = par_id + IDW'(1) + IDW'(qsra_pkg::times_slot(k[1:0], csz_child));
        state_next = S_FCHK;
      end

      S_FCHK: begin
        if (k != 3'd4) begin
          all_free_next = all_free & st_rd[qsra_pkg::FREE_BIT];
          k_next        = k + 3'd1;
          state_next    = S_FRD;
        end else begin
          mem_we  = 1'b1;
          wr_id   = par_id;
          mem_wd  = st_rd | (STW'(1) << par_ci) | (all_free ? qsra_pkg::FREE_MASK : '0);
          sp_next = sp - LW'(1);
          if (sp == LW'(1)) begin
            state_next = S_DONE;
          end else begin
            k_next        = '0;
            all_free_next = 1'b1;
            state_next    = S_FRD;
          end
        end
      end

      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      sp       <= '0;
      k        <= '0;
      ret_hit  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      sp       <= sp_next;
      k        <= k_next;
      ret_hit  <= ret_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    all_free <= all_free_next;
    ret_st   <= ret_st_next;
    op_free  <= op_free_next;
    want     <= want_next;
    req_id   <= req_id_next;
    cur_id   <= cur_id_next;
    cur_x    <= cur_x_next;
    cur_y    <= cur_y_next;
    if (stk_we) begin
      stk_id[stk_wi] <= stk_wid;
      stk_st[stk_wi] <= stk_wst;
      stk_ci[stk_wi] <= stk_wci;
      stk_x[stk_wi]  <= stk_wx;
      stk_y[stk_wi]  <= stk_wy;
    end
  end

  // ids past the node count read as exhausted
  assign rd_inr = (rd_id < IDW'(NODE_COUNT));
  assign mem_ra = rd_inr ? rd_id[AW-1:0] : '0;
  assign mem_wa = wr_id[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q  <= mem[mem_ra];
    rd_ok <= rd_inr;
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status = op_free ? qsra_pkg::RS_FREED
                         : (ret_hit ? qsra_pkg::RS_GRANTED : qsra_pkg::RS_NO_SPACE);
    res.id     = op_free ? req_id[qsra_pkg::ID_W-1:0]
                         : (ret_hit ? cur_id[qsra_pkg::ID_W-1:0] : '0);
    res.x      = ret_hit ? cur_x : '0;
    res.y      = ret_hit ? cur_y : '0;
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= LW'(TREE_DEPTH))
    else $error("ancestor stack overflow");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("status memory written while no walk is running");

  a_ret_has_parent: assert property (@(posedge clk) disable iff (rst)
    (state == S_RET || state == S_FRD || state == S_FCHK) |-> sp != '0)
    else $error("return step with an empty stack");

  a_grant_flags_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && mem_we) |=> ret_hit)
    else $error("grant write without a hit flag");

  a_parent_write_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCHK && mem_we) |-> k == 3'd4)
    else $error("parent updated before all children were checked");

endmodule

`default_nettype wire

>>> rtl/core/quadtree_square_region_allocator.sv
// ----------------------------------------------------------------------------
// quadtree_square_region_allocator
// 2D buddy allocator over a complete quadtree of square regions.
// ----------------------------------------------------------------------------
// usage:
//   req  : one transaction per allocate (op 0, size_level) or free (op 1, node_id)
//   rsp  : one transaction per request: status, id, top-left position, layer
//   cfg  : cfg_we/cfg_index/cfg_data write top_size_log2 (0) and layer_index (1)
//          while the block is idle
// flow: one request at a time; req.ready is high only when the walker is idle.
//   allocate: depth-first walk that reads each visited node and steps back
//   up when a subtree is done. free: one level per step on the way down,
//   then four child reads and the parent read per ancestor (one memory
//   port). the result then moves into the output register.
// reset: a clearing pass writes every status entry free, with req.ready low;
//   config registers return to 12 and 0 at once.
// stall: the result sits in the output register until rsp.ready; the next
//   request is taken meanwhile, and its result waits in the walker until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module quadtree_square_region_allocator #(
  parameter int TREE_DEPTH = qsra_pkg::DEF_TREE_DEPTH,
  parameter int NODE_COUNT = qsra_pkg::DEF_NODE_COUNT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  qsra_req_if.sink                               req,
  qsra_rsp_if.source                             rsp,
  input  wire logic                              cfg_we,
  input  wire logic [qsra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qsra_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [qsra_pkg::TSL_W-1:0]   top_size_log2;
  logic [qsra_pkg::LAYER_W-1:0] layer_index;

  logic                 eng_ready;
  logic                 start;
  qsra_pkg::qsra_cmd_t  cmd;
  logic                 res_valid;
  logic                 res_ready;
  qsra_pkg::qsra_res_t  res;

  logic                 rsp_valid;
  qsra_pkg::qsra_res_t  rsp_q;
  logic [qsra_pkg::LAYER_W-1:0] rsp_layer;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_size_log2 <= qsra_pkg::TSL_RESET;
      layer_index   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qsra_pkg::CFG_TOP_SIZE: top_size_log2 <= cfg_data[qsra_pkg::TSL_W-1:0];
        qsra_pkg::CFG_LAYER:    layer_index   <= cfg_data[qsra_pkg::LAYER_W-1:0];
        default:                layer_index   <= layer_index;
      endcase
    end
  end

  assign req.ready = eng_ready;
  assign start     = req.valid && eng_ready;
  assign cmd.op    = req.op;
  assign cmd.level = req.size_level;
  assign cmd.id    = req.node_id;

  qsra_engine #(
    .TREE_DEPTH (TREE_DEPTH),
    .NODE_COUNT (NODE_COUNT)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .top_size_log2 (top_size_log2),
    .ready         (eng_ready),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  // output register parts the walker from the receiver
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_q     <= res;
      rsp_layer <= (res.status == qsra_pkg::RS_NO_SPACE) ? '0 : layer_index;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_q.status;
  assign rsp.granted_id = rsp_q.id;
  assign rsp.pos_x      = rsp_q.x;
  assign rsp.pos_y      = rsp_q.y;
  assign rsp.layer_out  = rsp_layer;

endmodule

`default_nettype wire

>>> sim/quadtree_square_region_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadtree_square_region_allocator_tb
// Self-checking bench for the quadtree region allocator. A directed table
// covers the empty tree, the full root, levels that are too deep, bad ids and
// frees of free nodes. Random phases follow, each with its own region size and
// layer. Allocates and frees of held regions are mixed with stray frees. A
// local model of the status tree predicts every reply, and the replies are
// checked in order while both channels stall at random.
// ----------------------------------------------------------------------------

module quadtree_square_region_allocator_tb;

  localparam int OP_W       = qsra_pkg::OP_W;
  localparam int LEVEL_W    = qsra_pkg::LEVEL_W;
  localparam int ID_W       = qsra_pkg::ID_W;
  localparam int POS_W      = qsra_pkg::POS_W;
  localparam int LAYER_W    = qsra_pkg::LAYER_W;
  localparam int STATUS_W   = qsra_pkg::STATUS_W;
  localparam int TSL_W      = qsra_pkg::TSL_W;
  localparam int CFG_IDX_W  = qsra_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = qsra_pkg::CFG_DATA_W;
  localparam int ST_W       = qsra_pkg::ST_W;

  localparam int DEPTH          = qsra_pkg::DEF_TREE_DEPTH;
  localparam int NODES          = qsra_pkg::DEF_NODE_COUNT;
  localparam int DIR_ROWS       = 21;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam int HELD_CAP       = 40;
  localparam int HOLD_AFTER     = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [LAYER_W-1:0]  layer;
  } region_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LEVEL_W-1:0]  level;
    logic [ID_W-1:0]     id;
    logic                typed;
    logic [STATUS_W-1:0] e_status;
    logic [ID_W-1:0]     e_id;
    logic [POS_W-1:0]    e_x;
    logic [POS_W-1:0]    e_y;
    logic [LAYER_W-1:0]  e_layer;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qsra_req_if req_ch ();
  qsra_rsp_if rsp_ch ();

  quadtree_square_region_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // model of the allocator state
  logic [ST_W-1:0]    tree_state [NODES];
  logic [TSL_W-1:0]   side_log2;
  logic [LAYER_W-1:0] layer_sel;

  region_reply_t awaited_replies [$];
  int            mismatches  = 0;
  int            random_sent = 0;
  logic          hold_off    = 1'b0;
  logic          tx_calm     = 1'b0;
  logic          rx_calm     = 1'b0;

  function automatic int subtree_nodes(input int level);
    int s;
    int p;
    s = 0;
    p = 1;
    for (int l = level; l <= DEPTH; l++) begin
      s += p;
      p *= 4;
    end
    return s;
  endfunction

  // side of a child of a node at this level, zero once it drops below a texel
  function automatic int unsigned half_side(input int level);
    if (int'(side_log2) < level + 1) return 0;
    return 32'd1 << (int'(side_log2) - level - 1);
  endfunction

  // preorder depth-first search, unrolled onto an explicit stack
  function automatic region_reply_t walk_allocate(input int want);
    int            fnode [DEPTH+1];
    int unsigned   fx    [DEPTH+1];
    int unsigned   fy    [DEPTH+1];
    int            fslot [DEPTH+1];
    int            top;
    int            n;
    int            c;
    int            i;
    int unsigned   h;
    logic          hit;
    logic          done;
    region_reply_t r;
    r        = '0;
    r.status = qsra_pkg::RS_NO_SPACE;
    top      = 0;
    fnode[0] = 0;
    fx[0]    = 0;
    fy[0]    = 0;
    done     = 1'b0;
    while (!done) begin
      n   = fnode[top];
      hit = 1'b0;
      if (tree_state[n] != '0 && top == want) begin
        if (tree_state[n][qsra_pkg::FREE_BIT]) begin
          tree_state[n] = '0;
          hit      = 1'b1;
          r.status = qsra_pkg::RS_GRANTED;
          r.id     = n[ID_W-1:0];
          r.x      = fx[top][POS_W-1:0];
          r.y      = fy[top][POS_W-1:0];
          r.layer  = layer_sel;
        end
        done = 1'b1;
      end else if (tree_state[n] != '0 && top < DEPTH) begin
        fslot[top] = 0;
      end else begin
        done = 1'b1;
      end
      // climb back, pruning exhausted children, until a sibling is left to try
      while (done && top > 0) begin
        top = top - 1;
        c   = fnode[top+1];
        i   = fslot[top];
        n   = fnode[top];
        if (tree_state[c] == '0) tree_state[n][i] = 1'b0;
        if (hit) begin
          tree_state[n][qsra_pkg::FREE_BIT] = 1'b0;
        end else if (i < 3) begin
          fslot[top] = i + 1;
          done       = 1'b0;
        end
      end
      if (!done) begin
        i            = fslot[top];
        h            = half_side(top);
        fnode[top+1] = fnode[top] + 1 + i * subtree_nodes(top + 1);
        fx[top+1]    = fx[top] + (i[0] ? h : 32'd0);
        fy[top+1]    = fy[top] + (i[1] ? h : 32'd0);
        top          = top + 1;
      end
    end
    return r;
  endfunction

  function automatic region_reply_t walk_release(input logic [ID_W-1:0] id_in);
    int              path [DEPTH];
    int              slot [DEPTH];
    int              id;
    int              n;
    int              lvl;
    int              cnt;
    int              csz;
    int              pick;
    int              p;
    int unsigned     x;
    int unsigned     y;
    logic            found;
    logic            going;
    logic            all_free;
    logic [ST_W-1:0] v;
    region_reply_t   r;
    id    = int'(id_in);
    n     = 0;
    lvl   = 0;
    cnt   = 0;
    x     = 0;
    y     = 0;
    found = 1'b0;
    going = 1'b1;
    while (going) begin
      if (n == id) begin
        found = 1'b1;
        going = 1'b0;
      end else if (lvl == DEPTH || id < n + 1) begin
        going = 1'b0;
      end else begin
        csz = subtree_nodes(lvl + 1);
        if (id >= n + 1 + 4 * csz) begin
          going = 1'b0;
        end else begin
          pick = 0;
          for (int i = 1; i < 4; i++) if (n + 1 + i * csz <= id) pick = i;
          path[cnt] = n;
          slot[cnt] = pick;
          cnt++;
          x += pick[0] ? half_side(lvl) : 32'd0;
          y += pick[1] ? half_side(lvl) : 32'd0;
          n = n + 1 + pick * csz;
          lvl++;
        end
      end
    end
    r        = '0;
    r.status = qsra_pkg::RS_FREED;
    r.id     = id_in;
    r.layer  = layer_sel;
    if (found && id < NODES) begin
      r.x            = x[POS_W-1:0];
      r.y            = y[POS_W-1:0];
      tree_state[id] = qsra_pkg::ST_FREE;
      for (int k = cnt; k > 0; k--) begin
        p        = path[k-1];
        csz      = subtree_nodes(k);
        v        = tree_state[p] | (ST_W'(1) << slot[k-1]);
        all_free = 1'b1;
        for (int j = 0; j < 4; j++) begin
          if (!tree_state[p + 1 + j * csz][qsra_pkg::FREE_BIT]) all_free = 1'b0;
        end
        if (all_free) v[qsra_pkg::FREE_BIT] = 1'b1;
        tree_state[p] = v;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(input int k);
    dir_row_t t;
    case (k)
      0:  t = '{qsra_pkg::OP_ALLOC, 3'd0, 9'd0,   1'b1,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      1:  t = '{qsra_pkg::OP_ALLOC, 3'd0, 9'd511, 1'b1,
                qsra_pkg::RS_NO_SPACE, 9'd0,   14'd0, 14'd0, 8'd0};
      2:  t = '{qsra_pkg::OP_ALLOC, 3'd4, 9'd0,   1'b1,
                qsra_pkg::RS_NO_SPACE, 9'd0,   14'd0, 14'd0, 8'd0};
      3:  t = '{qsra_pkg::OP_FREE,  3'd7, 9'd0,   1'b1,
                qsra_pkg::RS_FREED,    9'd0,   14'd0, 14'd0, 8'd0};
      4:  t = '{qsra_pkg::OP_ALLOC, 3'd5, 9'd170, 1'b1,
                qsra_pkg::RS_NO_SPACE, 9'd0,   14'd0, 14'd0, 8'd0};
      5:  t = '{qsra_pkg::OP_ALLOC, 3'd7, 9'd511, 1'b1,
                qsra_pkg::RS_NO_SPACE, 9'd0,   14'd0, 14'd0, 8'd0};
      6:  t = '{qsra_pkg::OP_FREE,  3'd0, 9'd511, 1'b1,
                qsra_pkg::RS_FREED,    9'd511, 14'd0, 14'd0, 8'd0};
      7:  t = '{qsra_pkg::OP_FREE,  3'd2, 9'd341, 1'b1,
                qsra_pkg::RS_FREED,    9'd341, 14'd0, 14'd0, 8'd0};
      8:  t = '{qsra_pkg::OP_ALLOC, 3'd1, 9'd85,  1'b1,
                qsra_pkg::RS_GRANTED,  9'd1,   14'd0, 14'd0, 8'd0};
      9:  t = '{qsra_pkg::OP_ALLOC, 3'd1, 9'd0,   1'b1,
                qsra_pkg::RS_GRANTED,  9'd86,  14'd2048, 14'd0, 8'd0};
      10: t = '{qsra_pkg::OP_ALLOC, 3'd4, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      11: t = '{qsra_pkg::OP_ALLOC, 3'd2, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      12: t = '{qsra_pkg::OP_ALLOC, 3'd3, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      13: t = '{qsra_pkg::OP_FREE,  3'd5, 9'd340, 1'b0,
                qsra_pkg::RS_FREED,    9'd0,   14'd0, 14'd0, 8'd0};
      14: t = '{qsra_pkg::OP_FREE,  3'd0, 9'd86,  1'b0,
                qsra_pkg::RS_FREED,    9'd0,   14'd0, 14'd0, 8'd0};
      15: t = '{qsra_pkg::OP_ALLOC, 3'd0, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      16: t = '{qsra_pkg::OP_FREE,  3'd1, 9'd1,   1'b0,
                qsra_pkg::RS_FREED,    9'd0,   14'd0, 14'd0, 8'd0};
      17: t = '{qsra_pkg::OP_ALLOC, 3'd4, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      18: t = '{qsra_pkg::OP_FREE,  3'd3, 9'd0,   1'b0,
                qsra_pkg::RS_FREED,    9'd0,   14'd0, 14'd0, 8'd0};
      19: t = '{qsra_pkg::OP_ALLOC, 3'd3, 9'd0,   1'b0,
                qsra_pkg::RS_GRANTED,  9'd0,   14'd0, 14'd0, 8'd0};
      default: t = '{qsra_pkg::OP_ALLOC, 3'd6, 9'd0, 1'b1,
                     qsra_pkg::RS_NO_SPACE, 9'd0, 14'd0, 14'd0, 8'd0};
    endcase
    return t;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int s;
    s = $urandom_range(0, 99);
    if (s < 4)  return 3'd0;
    if (s < 12) return 3'd1;
    if (s < 37) return 3'd2;
    if (s < 67) return 3'd3;
    if (s < 95) return 3'd4;
    return LEVEL_W'($urandom_range(5, 7));
  endfunction

  // drive one request and return the model's reply once it is accepted
  task automatic offer(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] lvl,
                       input logic [ID_W-1:0] id, output region_reply_t pred);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.size_level <= lvl;
    req_ch.node_id    <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == qsra_pkg::OP_ALLOC) pred = walk_allocate(int'(lvl));
    else pred = walk_release(id);
  endtask

  task automatic load_config(input logic [TSL_W-1:0] tsl, input logic [LAYER_W-1:0] layer);
    cfg_we    <= 1'b1;
    cfg_index <= qsra_pkg::CFG_TOP_SIZE;
    cfg_data  <= {4'($urandom), tsl};
    @(posedge clk);
    side_log2 = tsl;
    cfg_index <= qsra_pkg::CFG_LAYER;
    cfg_data  <= layer;
    @(posedge clk);
    layer_sel = layer;
    cfg_we <= 1'b0;
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input region_reply_t want,
                               input region_reply_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: exp st=%0d id=%0d x=%0d y=%0d layer=%0d,",
               $realtime, what, want.status, want.id, want.x, want.y, want.layer);
      $display("    got st=%0d id=%0d x=%0d y=%0d layer=%0d",
               got.status, got.id, got.x, got.y, got.layer);
    end
  endtask

  // request side
  initial begin : request_source
    dir_row_t             row;
    region_reply_t        pred;
    region_reply_t        typed_reply;
    logic [ID_W-1:0]      held [$];
    logic [OP_W-1:0]      op;
    logic [LEVEL_W-1:0]   lvl;
    logic [ID_W-1:0]      id;
    logic [TSL_W-1:0]     tsl;
    logic [LAYER_W-1:0]   layer;
    int                   r;
    int                   k;
    int                   sent;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= qsra_pkg::CFG_TOP_SIZE;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= qsra_pkg::OP_ALLOC;
    req_ch.size_level <= '0;
    req_ch.node_id    <= '0;
    for (int i = 0; i < NODES; i++) tree_state[i] = qsra_pkg::ST_FREE;
    side_log2 = qsra_pkg::TSL_RESET;
    layer_sel = '0;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      row = dir_row(k);
      offer(row.op, row.level, row.id, pred);
      if (row.typed) begin
        typed_reply.status = row.e_status;
        typed_reply.id     = row.e_id;
        typed_reply.x      = row.e_x;
        typed_reply.y      = row.e_y;
        typed_reply.layer  = row.e_layer;
        awaited_replies.push_back(typed_reply);
      end else begin
        awaited_replies.push_back(pred);
      end
      sent++;
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_replies();
      case (ph)
        0: begin tsl = 4'd14; layer = 8'hFF; end
        1: begin tsl = 4'd6;  layer = 8'h00; end
        2: begin tsl = 4'd15; layer = 8'hA5; end
        3: begin tsl = 4'd0;  layer = 8'h5A; end
        4: begin tsl = 4'd1;  layer = 8'($urandom); end
        default: begin tsl = 4'($urandom_range(6, 14)); layer = 8'($urandom); end
      endcase
      load_config(tsl, layer);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sent % 32 == 0) tx_calm = ($urandom_range(0, 4) == 0);
        r   = $urandom_range(0, 99);
        lvl = LEVEL_W'($urandom);
        id  = ID_W'($urandom);
        if (held.size() > HELD_CAP && r < 45) r = 60;
        if (r < 45 || (r < 85 && held.size() == 0)) begin
          op  = qsra_pkg::OP_ALLOC;
          lvl = pick_level();
        end else if (r < 85) begin
          // release a region that an earlier grant handed out
          op = qsra_pkg::OP_FREE;
          k  = $urandom_range(0, held.size() - 1);
          id = held[k];
          held.delete(k);
        end else if (r < 95) begin
          op = qsra_pkg::OP_FREE;
          id = ID_W'($urandom_range(0, NODES - 1));
        end else begin
          op = qsra_pkg::OP_FREE;
          id = ID_W'($urandom_range(0, 511));
        end
        offer(op, lvl, id, pred);
        awaited_replies.push_back(pred);
        if (op == qsra_pkg::OP_ALLOC && pred.status == qsra_pkg::RS_GRANTED) begin
          held.push_back(pred.id);
        end
        sent++;
        random_sent++;
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("** quadtree_square_region_allocator: PASSED **");
    end else begin
      $display("** quadtree_square_region_allocator: FAILED **");
    end
    $finish;
  end

  // reply side
  initial begin : reply_sink
    region_reply_t got;
    region_reply_t want;
    int            stall;
    int            cyc;
    stall = 0;
    cyc   = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.id     = rsp_ch.granted_id;
        got.x      = rsp_ch.pos_x;
        got.y      = rsp_ch.pos_y;
        got.layer  = rsp_ch.layer_out;
        if (awaited_replies.size() == 0) begin
          note_mismatch("reply with no request pending", '0, got);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status || got.id !== want.id || got.x !== want.x ||
              got.y !== want.y || got.layer !== want.layer) begin
            note_mismatch("reply mismatch", want, got);
          end
        end
      end
      cyc++;
      if (cyc % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // one long back-pressure window so the request side backs up
  initial begin : long_hold
    wait (random_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** quadtree_square_region_allocator: FAILED **");
    $finish;
  end

endmodule
